// ----- rtl/core/onpr_pkg.sv -----
// ----------------------------------------------------------------------------
// onpr_pkg: shared types and constants of the Omega network path router
// Request and response items, link table entry, operation codes and
// sequencer states.
// ----------------------------------------------------------------------------
package onpr_pkg;

  // Default network shape
  localparam int STAGES_DEF       = 3;
  localparam int EXTRA_STAGES_DEF = 1;

  // Fixed field widths of the item ports
  localparam int PORT_FIELD_W = 6;
  localparam int PATH_W       = 14;
  localparam int USERS_W      = 7;
  localparam int TAG_W        = 2;

  // Saturation level of a link's user count
  localparam logic [USERS_W-1:0] USERS_MAX = 7'd127;

  typedef enum logic [1:0] {
    KIND_ROUTE_ANY = 2'd0,
    KIND_ROUTE_ONE = 2'd1,
    KIND_RELEASE   = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [PORT_FIELD_W-1:0] src_port;
    logic [PORT_FIELD_W-1:0] dst_port;
    logic [1:0]              extra_choice;
    logic [PATH_W-1:0]       release_word;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [PATH_W-1:0] path_word;
  } rsp_t;

  typedef struct packed {
    logic [USERS_W-1:0] users;
    logic [TAG_W-1:0]   tag;
  } link_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/omega_network_path_router_unit.sv -----
// ----------------------------------------------------------------------------
// omega_network_path_router_unit: circuit path allocator for a radix-4
// Omega network with extra stages
// Checks, claims and releases the links of source|extra|destination paths
// in a link table held in one RAM, one column per step.
// ----------------------------------------------------------------------------
// The block handles one item at a time; req_stall is high from acceptance
// until the result has been placed in the output register, which may still
// hold an earlier result while a new item is being worked on. Every column
// costs one RAM read and, when claiming or releasing, one RAM write, through
// a single read/write port pair, so the link RAM sets the pace. With
// C = STAGES + EXTRA_STAGES columns: a route checks the C columns once per
// extra value tried (a try stops at the first column that conflicts; up to
// 4^EXTRA_STAGES tries when all extras are scanned), then claims the C
// columns of the path that passed and posts the result; a failed route
// skips the claim. A release updates each of the C columns, then posts the
// result. A clear command sweeps the whole link table, one entry a cycle,
// 4^STAGES * C entries (256 by default), then posts the result. The same
// sweep runs after reset, and no item is accepted until it is done.
module omega_network_path_router_unit
  import onpr_pkg::*;
#(
  parameter int STAGES       = STAGES_DEF,
  parameter int EXTRA_STAGES = EXTRA_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int PORT_W      = 2 * STAGES;
  localparam int EX_W        = 2 * EXTRA_STAGES;
  localparam int COLS        = STAGES + EXTRA_STAGES;
  localparam int WORD_W      = 2 * PORT_W + EX_W;
  localparam int EXTRA_COUNT = 1 << EX_W;
  localparam int ECW         = (EX_W > 0) ? EX_W : 1;
  localparam int CW          = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int LINKS       = COLS << PORT_W;
  localparam int LINK_AW     = $clog2(LINKS);
  localparam int ENTRY_W     = $bits(link_entry_t);

  localparam logic [ECW-1:0]     EXTRA_MASK = ECW'(EXTRA_COUNT - 1);
  localparam logic [CW-1:0]      LAST_COL   = CW'(COLS - 1);
  localparam logic [LINK_AW-1:0] LAST_LINK  = LINK_AW'(LINKS - 1);

  // Sequencer and control state
  state_t               state, state_next;
  logic                 claim;        // check passed, now claiming links
  logic                 single;       // only one extra value to try
  logic                 clr_reply;    // clear sweep answers a command
  logic [LINK_AW-1:0]   clr_addr;
  logic [CW-1:0]        col;
  logic [ECW-1:0]       extra_cnt;
  logic                 ok_r;

  // Payload registers
  logic [PORT_FIELD_W-1:0] src_r;
  logic [PORT_FIELD_W-1:0] dst_r;
  logic [WORD_W-1:0]       sw;        // path word shifted left by 2*col

  // Link table port
  logic               ram_we;
  logic [LINK_AW-1:0] ram_waddr;
  logic [LINK_AW-1:0] ram_raddr;
  link_entry_t        ram_wdata;
  link_entry_t        ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic               req_take;
  logic               rsp_load;
  logic [WORD_W-1:0]  word_base;
  logic [PORT_W-1:0]  cur_idx;
  logic [TAG_W-1:0]   cur_tag;
  logic [LINK_AW-1:0] link_addr;
  logic               conflict;
  logic               last_col;
  logic               last_extra;
  link_entry_t        upd_entry;

  onpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = link_entry_t'(ram_rbits);
  assign req_take  = req_valid && !req_stall;

  // Path word for the current extra value: source | extra | destination
  assign word_base = (WORD_W'(PORT_W'(src_r)) << (PORT_W + EX_W))
                   | (WORD_W'(extra_cnt & EXTRA_MASK) << PORT_W)
                   | WORD_W'(PORT_W'(dst_r));

  // Column window sits just below the top digit of the shifted word; the
  // top digit is the column's tag.
  assign cur_tag   = sw[WORD_W-1 -: TAG_W];
  assign cur_idx   = sw[WORD_W-3 -: PORT_W];
  assign link_addr = LINK_AW'(LINK_AW'(cur_idx) * LINK_AW'(COLS)) + LINK_AW'(col);

  assign conflict   = (ram_rdata.users != '0) && (ram_rdata.tag != cur_tag);
  assign last_col   = (col == LAST_COL);
  assign last_extra = single || (extra_cnt == EXTRA_MASK);

  // Shared update unit: saturating claim or floor-at-zero release
  always_comb begin
    upd_entry = ram_rdata;
    if (claim) begin
      if (ram_rdata.users != USERS_MAX) begin
        upd_entry.users = ram_rdata.users + USERS_W'(1);
      end
      upd_entry.tag = cur_tag;
    end else if (ram_rdata.users != '0) begin
      upd_entry.users = ram_rdata.users - USERS_W'(1);
      if (ram_rdata.users == USERS_W'(1)) begin
        upd_entry.tag = '0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_LINK) begin
          state_next = clr_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_take) begin
          case (req.kind)
            KIND_ROUTE_ANY, KIND_ROUTE_ONE: state_next = ST_LOAD;
            KIND_RELEASE:                   state_next = ST_UPD_RD;
            default:                        state_next = ST_CLEAR;
          endcase
        end
      end
      ST_LOAD:   state_next = claim ? ST_UPD_RD : ST_CHK_RD;
      ST_CHK_RD: state_next = ST_CHK_EV;
      ST_CHK_EV: begin
        if (conflict) begin
          state_next = last_extra ? ST_DONE : ST_LOAD;
        end else begin
          state_next = last_col ? ST_LOAD : ST_CHK_RD;
        end
      end
      ST_UPD_RD: state_next = ST_UPD_WR;
      ST_UPD_WR: state_next = last_col ? ST_DONE : ST_UPD_RD;
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall = (state != ST_IDLE);
    rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
    ram_raddr = link_addr;
    ram_we    = 1'b0;
    ram_waddr = link_addr;
    ram_wdata = upd_entry;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_UPD_WR: ram_we = 1'b1;
      default:   ram_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_reply <= 1'b0;
      clr_addr  <= '0;
      claim     <= 1'b0;
      single    <= 1'b0;
      col       <= '0;
      extra_cnt <= '0;
      ok_r      <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + LINK_AW'(1);
        ST_IDLE: begin
          if (req_take) begin
            claim     <= 1'b0;
            ok_r      <= 1'b1;
            col       <= '0;
            clr_addr  <= '0;
            clr_reply <= (req.kind == KIND_CLEAR);
            single    <= (req.kind == KIND_ROUTE_ONE);
            extra_cnt <= (req.kind == KIND_ROUTE_ONE) ?
                         (ECW'(req.extra_choice) & EXTRA_MASK) : '0;
          end
        end
        ST_LOAD: col <= '0;
        ST_CHK_EV: begin
          if (conflict) begin
            if (last_extra) begin
              ok_r <= 1'b0;
            end else begin
              extra_cnt <= extra_cnt + ECW'(1);
            end
          end else if (last_col) begin
            claim <= 1'b1;
          end else begin
            col <= col + CW'(1);
          end
        end
        ST_UPD_WR: begin
          if (!last_col) begin
            col <= col + CW'(1);
          end
        end
        default: ;
      endcase
      // Hold the result until taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          src_r <= req.src_port;
          dst_r <= req.dst_port;
          sw    <= WORD_W'(req.release_word);
        end
      end
      ST_LOAD: sw <= word_base;
      ST_CHK_EV: begin
        if (!conflict && !last_col) begin
          sw <= sw << 2;
        end
      end
      ST_UPD_WR: begin
        if (!last_col) begin
          sw <= sw << 2;
        end
      end
      default: ;
    endcase
    if (rsp_load) begin
      rsp.ok        <= ok_r;
      rsp.path_word <= claim ? PATH_W'(word_base) : '0;
    end
  end

  // A new result only ever comes from the result-posting step
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DONE))
    else $error("result posted outside the result-posting step");

  // A failed route never hands out a path word
  a_fail_no_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.path_word == '0)
    else $error("failed route carries a path word");

  // Claiming a link leaves it with at least one user
  a_claim_nonzero: assert property (@(posedge clk) disable iff (rst)
    ram_we && (state == ST_UPD_WR) && claim |-> ram_wdata.users != '0)
    else $error("claimed link written with zero users");

  // The check phase runs only before any link is claimed
  a_check_no_claim: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK_RD) || (state == ST_CHK_EV) |-> !claim)
    else $error("link check running after claim started");

endmodule

// ----- rtl/core/onpr_ram.sv -----
// ----------------------------------------------------------------------------
// onpr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module onpr_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- bench/path_check_pkg.sv -----
// ----------------------------------------------------------------------------
// path_check_pkg: link table predictor and result scoreboard
// Keeps its own copy of the link table, predicts the answer to every
// accepted request and compares it with the answers the router returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package path_check_pkg;
  import onpr_pkg::*;

  localparam int NET_STAGES  = STAGES_DEF;
  localparam int NET_EXTRA   = EXTRA_STAGES_DEF;
  localparam int NET_COLS    = NET_STAGES + NET_EXTRA;
  localparam int NET_PORTS   = 1 << (2 * NET_STAGES);
  localparam int PORT_MASK   = NET_PORTS - 1;
  localparam int EXTRA_COUNT = 1 << (2 * NET_EXTRA);
  localparam int EXTRA_MASK  = EXTRA_COUNT - 1;
  localparam int WORD_BITS   = 2 * (2 * NET_STAGES + NET_EXTRA);
  localparam int WORD_MASK   = (1 << WORD_BITS) - 1;
  localparam int LINK_COUNT  = NET_PORTS * NET_COLS;

  class path_scoreboard;
    logic [USERS_W-1:0] users [LINK_COUNT];
    logic [TAG_W-1:0]   tags  [LINK_COUNT];
    rsp_t               answer_q[$];
    logic [PATH_W-1:0]  granted_words[$];
    int                 errors;

    function new();
      wipe_links();
      errors = 0;
    endfunction

    function void wipe_links();
      for (int i = 0; i < LINK_COUNT; i++) begin
        users[i] = '0;
        tags[i]  = '0;
      end
      granted_words.delete();
    endfunction

    function int pending();
      return answer_q.size();
    endfunction

    // Column j uses the window of port bits ending 2*(COLS-1-j) above bit 0.
    function int unsigned link_index(int unsigned word, int col);
      int unsigned sh;
      sh = 2 * NET_COLS - 2 * (col + 1);
      return ((word >> sh) & PORT_MASK) * NET_COLS + col;
    endfunction

    // The digit just above the column's window.
    function logic [TAG_W-1:0] tag_digit(int unsigned word, int col);
      int unsigned sh;
      sh = 2 * (2 * NET_STAGES + NET_EXTRA - 1) - 2 * col;
      return TAG_W'((word >> sh) & 3);
    endfunction

    function int unsigned build_word(int unsigned src, int unsigned ex, int unsigned dst);
      return ((src & PORT_MASK) << (2 * NET_STAGES + 2 * NET_EXTRA))
           | ((ex & EXTRA_MASK) << (2 * NET_STAGES))
           | (dst & PORT_MASK);
    endfunction

    function bit claim_path(int unsigned word);
      int unsigned l;
      for (int c = 0; c < NET_COLS; c++) begin
        l = link_index(word, c);
        if (users[l] != 0 && tags[l] != tag_digit(word, c)) return 1'b0;
      end
      for (int c = 0; c < NET_COLS; c++) begin
        l = link_index(word, c);
        if (users[l] < USERS_MAX) users[l] = users[l] + 1'b1;
        tags[l] = tag_digit(word, c);
      end
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      rsp_t        ans;
      int unsigned word;
      int unsigned l;
      ans.ok        = 1'b1;
      ans.path_word = '0;
      case (r.kind)
        KIND_ROUTE_ANY: begin
          ans.ok = 1'b0;
          for (int ex = 0; ex < EXTRA_COUNT && !ans.ok; ex++) begin
            word = build_word(r.src_port, ex, r.dst_port);
            if (claim_path(word)) begin
              ans.ok        = 1'b1;
              ans.path_word = PATH_W'(word);
            end
          end
        end
        KIND_ROUTE_ONE: begin
          word = build_word(r.src_port, r.extra_choice, r.dst_port);
          if (claim_path(word)) ans.path_word = PATH_W'(word);
          else ans.ok = 1'b0;
        end
        KIND_RELEASE: begin
          word = r.release_word & WORD_MASK;
          for (int c = 0; c < NET_COLS; c++) begin
            l = link_index(word, c);
            if (users[l] != 0) begin
              users[l] = users[l] - 1'b1;
              if (users[l] == 0) tags[l] = '0;
            end
          end
        end
        default: wipe_links();
      endcase
      if ((r.kind == KIND_ROUTE_ANY || r.kind == KIND_ROUTE_ONE) && ans.ok)
        granted_words.push_back(ans.path_word);
      answer_q.push_back(ans);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (answer_q.size() == 0) begin
        if (errors < 10) $display("unexpected answer ok=%0b word=%h", got.ok, got.path_word);
        errors++;
        return;
      end
      want = answer_q.pop_front();
      if (got.ok !== want.ok || got.path_word !== want.path_word) begin
        if (errors < 10)
          $display("answer mismatch: expected ok=%0b word=%h, got ok=%0b word=%h",
                   want.ok, want.path_word, got.ok, got.path_word);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: bench for the Omega network path router
// Drives route, release and clear requests through the valid/stall
// handshake, with directed cases, a user count saturation run and random
// traffic under varying sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import onpr_pkg::*;
  import path_check_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  // Idling odds in percent, changed per phase
  int idle_pct  = 0;
  int stall_pct = 0;

  path_scoreboard sb = new();

  always #2 clk = ~clk;

  omega_network_path_router_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Check every answer taken at an edge, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard limit on the run: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic req_t request(kind_t k, logic [5:0] s, logic [5:0] d,
                                   logic [1:0] e, logic [13:0] w);
    req_t r;
    r.kind         = k;
    r.src_port     = s;
    r.dst_port     = d;
    r.extra_choice = e;
    r.release_word = w;
    return r;
  endfunction

  // Present one item, hold it until accepted, and note it at acceptance.
  // Valid stays high afterwards, so back-to-back items need not raise it again.
  task automatic send_item(req_t item);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(item);
  endtask

  // Drop valid and hold off until every answer owed has come back.
  task automatic drain_answers();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic: routes and releases of granted paths, with
  // releases of arbitrary words and the odd clear as noise. Every field is
  // filled at random first, so unused bits still toggle.
  function automatic req_t random_request();
    req_t        r;
    int          pick;
    int unsigned idx;
    r = request(kind_t'($urandom_range(3)), 6'($urandom_range(63)),
                6'($urandom_range(63)), 2'($urandom_range(3)),
                14'($urandom_range(16383)));
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.kind = KIND_ROUTE_ANY;
    end else if (pick < 60) begin
      r.kind = KIND_ROUTE_ONE;
    end else if (pick < 90) begin
      if (sb.granted_words.size() != 0) begin
        idx            = $urandom_range(sb.granted_words.size() - 1);
        r.kind         = KIND_RELEASE;
        r.release_word = sb.granted_words[idx];
        sb.granted_words.delete(idx);
      end else begin
        r.kind = KIND_ROUTE_ANY;
      end
    end else if (pick < 97) begin
      r.kind = KIND_RELEASE;
    end else begin
      r.kind = KIND_CLEAR;
    end
    return r;
  endfunction

  initial begin
    int idle_set [4];
    int stall_set[4];
    int waited;
    idle_set  = '{0, 67, 0, 37};
    stall_set = '{0, 0, 67, 37};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of the ports and extras, tag conflicts, fall-through
    // to later extras, repeated grants, releases of free links and of the
    // widest word, tag reset on last release, clear.
    send_item(request(KIND_CLEAR,     6'd0,  6'd0,  2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ANY, 6'd0,  6'd0,  2'd3, 14'h3FFF));
    send_item(request(KIND_ROUTE_ANY, 6'd63, 6'd63, 2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ONE, 6'd63, 6'd63, 2'd3, 14'd0));
    send_item(request(KIND_ROUTE_ONE, 6'd16, 6'd0,  2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ANY, 6'd16, 6'd0,  2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ONE, 6'd0,  6'd63, 2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ANY, 6'd5,  6'd9,  2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ANY, 6'd5,  6'd9,  2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ANY, 6'd48, 6'd0,  2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ANY, 6'd32, 6'd0,  2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ANY, 6'd32, 6'd0,  2'd0, 14'd0));
    send_item(request(KIND_RELEASE,   6'd63, 6'd63, 2'd3, 14'd0));
    send_item(request(KIND_RELEASE,   6'd0,  6'd0,  2'd0, 14'd0));
    send_item(request(KIND_ROUTE_ONE, 6'd16, 6'd0,  2'd0, 14'd0));
    send_item(request(KIND_RELEASE,   6'd0,  6'd0,  2'd0, 14'h3FFF));
    send_item(request(KIND_ROUTE_ONE, 6'd42, 6'd21, 2'd1, 14'd0));
    send_item(request(KIND_ROUTE_ONE, 6'd42, 6'd21, 2'd2, 14'd0));
    send_item(request(KIND_CLEAR,     6'd63, 6'd63, 2'd3, 14'h3FFF));
    drain_answers();

    // Push one path's link counts past saturation, then release them all
    // and a few more, and route a conflicting path over the freed links.
    repeat (130) send_item(request(KIND_ROUTE_ONE, 6'd21, 6'd42, 2'd2, 14'd0));
    repeat (132) begin
      send_item(request(KIND_RELEASE, 6'd0, 6'd0, 2'd0,
                        14'(sb.build_word(6'd21, 2'd2, 6'd42))));
    end
    send_item(request(KIND_ROUTE_ONE, 6'd37, 6'd42, 2'd2, 14'd0));
    send_item(request(KIND_CLEAR, 6'd0, 6'd0, 2'd0, 14'd0));
    drain_answers();

    // Random traffic, one phase per idling mix; hold off between phases.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      repeat (305) send_item(random_request());
      drain_answers();
    end

    req_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d answers never arrived", sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/onpr_pkg.sv
rtl/core/onpr_ram.sv
rtl/core/omega_network_path_router_unit.sv
bench/path_check_pkg.sv
bench/tb_top.sv
